>>> hw/rtl/ssg_pkg.sv
`timescale 1ns / 1ps

package ssg_pkg;

  localparam int FramePoints = 512;

  localparam int DataW  = 24;
  localparam int PowW   = 48;
  localparam int GainW  = 16;
  localparam int CfgW   = 16;
  localparam int InitW  = 4;
  localparam int AddrW  = 5;
  localparam int ApbW   = 32;
  localparam int AccW   = 66;

  // Default queue entry: two bin parts, a 9-bit bin index, last and active flags.
  localparam int ItemDefaultW = 2 * DataW + 9 + 2;

  localparam int DivSteps = 67;
  localparam int DivCntW  = 7;

  localparam logic [GainW-1:0] OneQ15 = 16'h8000;
  localparam logic [GainW:0]   OneQ16 = 17'h10000;

  typedef enum logic [2:0] {
    REG_OVER_SUB,
    REG_MIN_GAIN,
    REG_NOISE_SMOOTH,
    REG_GAIN_SMOOTH,
    REG_UPDATE_RATIO,
    REG_INIT_FRAMES
  } reg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0]  over_sub;
    logic [CfgW-1:0]  min_gain;
    logic [CfgW-1:0]  noise_smooth;
    logic [CfgW-1:0]  gain_smooth;
    logic [CfgW-1:0]  update_ratio;
    logic [InitW-1:0] init_frames;
  } cfg_t;

  typedef enum logic [4:0] {
    B_CLEAR,
    B_IDLE,
    B_SQ_RE,
    B_SQ_IM,
    B_PWR,
    B_RT_LO,
    B_RT_HI,
    B_RT_CMP,
    B_NS_LO,
    B_NS_HI,
    B_NP_LO,
    B_NP_HI,
    B_NS_WR,
    B_OS_LO,
    B_OS_HI,
    B_GCHK,
    B_DIV,
    B_INIT_WR,
    B_GAIN,
    B_NB,
    B_E_RD,
    B_E_T1,
    B_E_T2,
    B_E_WR,
    B_SC_RE,
    B_SC_IM,
    B_SC_FIN,
    B_PUT
  } back_state_e;

endpackage

>>> hw/rtl/ssg_queue.sv
`timescale 1ns / 1ps

module ssg_queue #(
  parameter int Width = ssg_pkg::ItemDefaultW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] head_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [Width-1:0] entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

>>> hw/rtl/ssg_front.sv
`timescale 1ns / 1ps

module ssg_front #(
  parameter int FRAME_POINTS = ssg_pkg::FramePoints,
  localparam int BinCount = FRAME_POINTS / 2 + 1,
  localparam int KW = $clog2(BinCount)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    queue_full_i,
  input  logic                    clearing_i,
  input  logic [ssg_pkg::InitW-1:0] init_frames_i,
  output logic                    in_stall_o,
  output logic                    push_o,
  output logic [KW-1:0]           k_o,
  output logic                    last_o,
  output logic                    active_o
);

  logic [KW-1:0]             pos_q;
  logic [ssg_pkg::InitW-1:0] frames_q;

  assign in_stall_o = queue_full_i | clearing_i;
  assign push_o     = in_valid_i & ~in_stall_o;
  assign k_o        = pos_q;
  assign last_o     = (pos_q == KW'(BinCount - 1));
  assign active_o   = (frames_q >= init_frames_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      frames_q <= '0;
    end else if (push_o) begin
      if (last_o) begin
        pos_q <= '0;
        // advance the frame count only during the initial phase
        if (frames_q < init_frames_i) frames_q <= frames_q + 4'd1;
      end else begin
        pos_q <= pos_q + KW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/ssg_back.sv
`timescale 1ns / 1ps

module ssg_back #(
  parameter int FRAME_POINTS = ssg_pkg::FramePoints,
  localparam int BinCount = FRAME_POINTS / 2 + 1,
  localparam int KW = $clog2(BinCount)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssg_pkg::cfg_t      cfg_i,
  input  logic               item_valid_i,
  input  logic signed [23:0] item_re_i,
  input  logic signed [23:0] item_im_i,
  input  logic [KW-1:0]      item_k_i,
  input  logic               item_last_i,
  input  logic               item_active_i,
  output logic               item_pop_o,
  output logic               clearing_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] out_real_o,
  output logic signed [23:0] out_imag_o,
  output logic               frame_last_o
);

  localparam int AccW = ssg_pkg::AccW;

  ssg_pkg::back_state_e state_q, state_d;

  logic [47:0] noise_mem [BinCount];
  logic [15:0] gain_mem  [BinCount];
  logic [47:0] noise_rd_q;
  logic [15:0] gain_rd_q;
  logic [KW-1:0] nz_ra, gn_wa;
  logic        nz_we, gn_we;
  logic [47:0] nz_wd;
  logic [15:0] gn_wd;

  logic [KW-1:0] clr_q;
  logic signed [23:0] re_q, im_q, held_re_q, held_im_q, eh_re_q, eh_im_q;
  logic [KW-1:0] k_q, ej_q;
  logic        last_q, active_q, elast_q;

  logic [AccW-1:0] acc_q, acc_d, prod_ext, addend;
  logic [23:0] mul_a, mul_b;
  logic [47:0] prod;
  logic        mul_hi, acc_clr, acc_en;

  logic [47:0] power_q, n_q;
  logic [66:0] dv_num_q;
  logic [47:0] dv_rem_q, dv_den_q, dv_quo_q, dv_r2;
  logic        dv_big_q, dv_init_q, dv_ge;
  logic [ssg_pkg::DivCntW-1:0] dv_cnt_q;

  logic [15:0] g_q, ng0_q, ng1_q, gp_q, gc_q, gn_q, f_q, ge_q, mg, g_calc, g_raw;
  logic [17:0] fsum;
  logic [48:0] init_sum;
  logic [AccW-1:0] rnd;
  logic [23:0] mag_re, mag_im, are, aim, res_re_q, res_im_q, sc_res;
  logic [23:0] out_re_q, out_im_q;
  logic        out_valid_q, out_last_q, out_load, big;
  logic [16:0] s_inv, t_inv;

  function automatic logic [23:0] mag24(input logic signed [23:0] x);
    mag24 = x[23] ? 24'(-x) : 24'(x);
  endfunction

  function automatic logic [23:0] round_scale(input logic [39:0] p, input logic neg);
    logic [40:0] t;
    logic [23:0] m;
    t = {1'b0, p} + 41'd16384;
    m = t[38:15];
    round_scale = neg ? 24'(-m) : m;
  endfunction

  assign are    = mag24(re_q);
  assign aim    = mag24(im_q);
  assign mag_re = mag24(eh_re_q);
  assign mag_im = mag24(eh_im_q);
  assign mg     = (cfg_i.min_gain > ssg_pkg::OneQ15) ? ssg_pkg::OneQ15 : cfg_i.min_gain;
  assign s_inv  = ssg_pkg::OneQ16 - {1'b0, cfg_i.noise_smooth};
  assign t_inv  = ssg_pkg::OneQ16 - {1'b0, cfg_i.gain_smooth};
  assign rnd    = acc_q + AccW'(32768);
  assign fsum   = {2'b00, gp_q} + {1'b0, gc_q, 1'b0} + {2'b00, gn_q} + 18'd2;
  assign init_sum = {1'b0, n_q} + {1'b0, dv_quo_q};
  assign sc_res = round_scale(acc_q[39:0], state_q == ssg_pkg::B_SC_IM ? eh_re_q[23]
                                                                      : eh_im_q[23]);

  // shared multiplier with accumulate
  assign prod     = mul_a * mul_b;
  assign prod_ext = {{(AccW-48){1'b0}}, prod};
  assign addend   = mul_hi ? (prod_ext << 24) : prod_ext;
  assign acc_d    = (acc_clr ? '0 : acc_q) + addend;

  // bit-serial restoring divider step
  assign dv_r2 = {dv_rem_q[46:0], dv_num_q[66]};
  assign dv_ge = (dv_r2 >= dv_den_q);

  assign big   = dv_big_q | (|dv_quo_q[47:15]);
  assign g_raw = ssg_pkg::OneQ15 - {1'b0, dv_quo_q[14:0]};
  assign g_calc = big ? mg : ((g_raw < mg) ? mg : g_raw);

  assign clearing_o   = (state_q == ssg_pkg::B_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign out_real_o   = out_re_q;
  assign out_imag_o   = out_im_q;
  assign frame_last_o = out_last_q;

  assign nz_ra = (state_q == ssg_pkg::B_IDLE) ? item_k_i : k_q;
  assign gn_wa = (state_q == ssg_pkg::B_CLEAR) ? clr_q : ej_q;

  always_ff @(posedge clk_i) begin
    if (nz_we) noise_mem[(state_q == ssg_pkg::B_CLEAR) ? clr_q : k_q] <= nz_wd;
    if (gn_we) gain_mem[gn_wa] <= gn_wd;
    noise_rd_q <= noise_mem[nz_ra];
    gain_rd_q  <= gain_mem[ej_q];
  end

  always_comb begin
    state_d    = state_q;
    mul_a      = '0;
    mul_b      = '0;
    mul_hi     = 1'b0;
    acc_clr    = 1'b0;
    acc_en     = 1'b0;
    item_pop_o = 1'b0;
    nz_we      = 1'b0;
    nz_wd      = '0;
    gn_we      = 1'b0;
    gn_wd      = '0;
    out_load   = 1'b0;
    case (state_q)
      ssg_pkg::B_CLEAR: begin
        nz_we = 1'b1;
        gn_we = 1'b1;
        gn_wd = ssg_pkg::OneQ15;
        if (clr_q == KW'(BinCount - 1)) state_d = ssg_pkg::B_IDLE;
      end
      ssg_pkg::B_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          state_d    = ssg_pkg::B_SQ_RE;
        end
      end
      ssg_pkg::B_SQ_RE: begin
        mul_a = are; mul_b = are; acc_clr = 1'b1; acc_en = 1'b1;
        state_d = ssg_pkg::B_SQ_IM;
      end
      ssg_pkg::B_SQ_IM: begin
        mul_a = aim; mul_b = aim; acc_en = 1'b1;
        state_d = ssg_pkg::B_PWR;
      end
      ssg_pkg::B_PWR: begin
        state_d = active_q ? ssg_pkg::B_RT_LO : ssg_pkg::B_DIV;
      end
      ssg_pkg::B_RT_LO: begin
        mul_a = 24'(cfg_i.update_ratio); mul_b = n_q[23:0];
        acc_clr = 1'b1; acc_en = 1'b1;
        state_d = ssg_pkg::B_RT_HI;
      end
      ssg_pkg::B_RT_HI: begin
        mul_a = 24'(cfg_i.update_ratio); mul_b = n_q[47:24];
        mul_hi = 1'b1; acc_en = 1'b1;
        state_d = ssg_pkg::B_RT_CMP;
      end
      ssg_pkg::B_RT_CMP: begin
        state_d = (AccW'({power_q, 12'h000}) < acc_q) ? ssg_pkg::B_NS_LO
                                                       : ssg_pkg::B_OS_LO;
      end
      ssg_pkg::B_NS_LO: begin
        mul_a = 24'(cfg_i.noise_smooth); mul_b = n_q[23:0];
        acc_clr = 1'b1; acc_en = 1'b1;
        state_d = ssg_pkg::B_NS_HI;
      end
      ssg_pkg::B_NS_HI: begin
        mul_a = 24'(cfg_i.noise_smooth); mul_b = n_q[47:24];
        mul_hi = 1'b1; acc_en = 1'b1;
        state_d = ssg_pkg::B_NP_LO;
      end
      ssg_pkg::B_NP_LO: begin
        mul_a = 24'(s_inv); mul_b = power_q[23:0]; acc_en = 1'b1;
        state_d = ssg_pkg::B_NP_HI;
      end
      ssg_pkg::B_NP_HI: begin
        mul_a = 24'(s_inv); mul_b = power_q[47:24];
        mul_hi = 1'b1; acc_en = 1'b1;
        state_d = ssg_pkg::B_NS_WR;
      end
      ssg_pkg::B_NS_WR: begin
        nz_we = 1'b1;
        nz_wd = rnd[63:16];
        state_d = ssg_pkg::B_OS_LO;
      end
      ssg_pkg::B_OS_LO: begin
        mul_a = 24'(cfg_i.over_sub); mul_b = n_q[23:0];
        acc_clr = 1'b1; acc_en = 1'b1;
        state_d = ssg_pkg::B_OS_HI;
      end
      ssg_pkg::B_OS_HI: begin
        mul_a = 24'(cfg_i.over_sub); mul_b = n_q[47:24];
        mul_hi = 1'b1; acc_en = 1'b1;
        state_d = ssg_pkg::B_GCHK;
      end
      ssg_pkg::B_GCHK: begin
        if (acc_q == '0 || power_q == '0) begin
          state_d = ssg_pkg::B_NB;
        end else begin
          state_d = ssg_pkg::B_DIV;
        end
      end
      ssg_pkg::B_DIV: begin
        if (dv_cnt_q == ssg_pkg::DivCntW'(ssg_pkg::DivSteps - 1)) begin
          state_d = dv_init_q ? ssg_pkg::B_INIT_WR : ssg_pkg::B_GAIN;
        end
      end
      ssg_pkg::B_INIT_WR: begin
        nz_we = 1'b1;
        nz_wd = init_sum[48] ? '1 : init_sum[47:0];
        state_d = ssg_pkg::B_NB;
      end
      ssg_pkg::B_GAIN: begin
        state_d = ssg_pkg::B_NB;
      end
      ssg_pkg::B_NB: begin
        state_d = (k_q == '0) ? ssg_pkg::B_IDLE : ssg_pkg::B_E_RD;
      end
      ssg_pkg::B_E_RD: begin
        state_d = active_q ? ssg_pkg::B_E_T1 : ssg_pkg::B_SC_RE;
      end
      ssg_pkg::B_E_T1: begin
        mul_a = 24'(cfg_i.gain_smooth); mul_b = 24'(gain_rd_q);
        acc_clr = 1'b1; acc_en = 1'b1;
        state_d = ssg_pkg::B_E_T2;
      end
      ssg_pkg::B_E_T2: begin
        mul_a = 24'(t_inv); mul_b = 24'(f_q); acc_en = 1'b1;
        state_d = ssg_pkg::B_E_WR;
      end
      ssg_pkg::B_E_WR: begin
        gn_we = 1'b1;
        gn_wd = rnd[31:16];
        state_d = ssg_pkg::B_SC_RE;
      end
      ssg_pkg::B_SC_RE: begin
        mul_a = 24'(ge_q); mul_b = mag_re; acc_clr = 1'b1; acc_en = 1'b1;
        state_d = ssg_pkg::B_SC_IM;
      end
      ssg_pkg::B_SC_IM: begin
        mul_a = 24'(ge_q); mul_b = mag_im; acc_clr = 1'b1; acc_en = 1'b1;
        state_d = ssg_pkg::B_SC_FIN;
      end
      ssg_pkg::B_SC_FIN: begin
        state_d = ssg_pkg::B_PUT;
      end
      ssg_pkg::B_PUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = (last_q && !elast_q) ? ssg_pkg::B_E_RD : ssg_pkg::B_IDLE;
        end
      end
      default: state_d = ssg_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssg_pkg::B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ssg_pkg::B_CLEAR) clr_q <= clr_q + KW'(1);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_en) acc_q <= acc_d;
    if (out_load) begin
      out_re_q   <= res_re_q;
      out_im_q   <= res_im_q;
      out_last_q <= elast_q;
    end
    case (state_q)
      ssg_pkg::B_IDLE: begin
        re_q     <= item_re_i;
        im_q     <= item_im_i;
        k_q      <= item_k_i;
        last_q   <= item_last_i;
        active_q <= item_active_i;
      end
      ssg_pkg::B_PWR: begin
        power_q <= acc_q[47:0];
        n_q     <= noise_rd_q;
        dv_num_q  <= {19'd0, acc_q[47:0]};
        dv_den_q  <= {44'd0, cfg_i.init_frames};
        dv_rem_q  <= '0;
        dv_quo_q  <= '0;
        dv_big_q  <= 1'b0;
        dv_cnt_q  <= '0;
        dv_init_q <= 1'b1;
      end
      ssg_pkg::B_NS_WR: n_q <= rnd[63:16];
      ssg_pkg::B_GCHK: begin
        g_q       <= (acc_q == '0) ? ssg_pkg::OneQ15 : mg;
        dv_num_q  <= {acc_q[63:0], 3'b000};
        dv_den_q  <= power_q;
        dv_rem_q  <= '0;
        dv_quo_q  <= '0;
        dv_big_q  <= 1'b0;
        dv_cnt_q  <= '0;
        dv_init_q <= 1'b0;
      end
      ssg_pkg::B_DIV: begin
        dv_rem_q <= dv_ge ? (dv_r2 - dv_den_q) : dv_r2;
        dv_quo_q <= {dv_quo_q[46:0], dv_ge};
        dv_big_q <= dv_big_q | dv_quo_q[47];
        dv_num_q <= {dv_num_q[65:0], 1'b0};
        dv_cnt_q <= dv_cnt_q + ssg_pkg::DivCntW'(1);
      end
      ssg_pkg::B_INIT_WR: g_q <= ssg_pkg::OneQ15;
      ssg_pkg::B_GAIN:    g_q <= g_calc;
      ssg_pkg::B_NB: begin
        if (k_q == '0) begin
          ng0_q <= g_q;
          ng1_q <= g_q;
        end else begin
          ej_q    <= k_q - KW'(1);
          gp_q    <= (k_q == KW'(1)) ? ng1_q : ng0_q;
          gc_q    <= ng1_q;
          gn_q    <= g_q;
          eh_re_q <= held_re_q;
          eh_im_q <= held_im_q;
          elast_q <= 1'b0;
          ng0_q   <= ng1_q;
          ng1_q   <= g_q;
        end
        held_re_q <= re_q;
        held_im_q <= im_q;
      end
      ssg_pkg::B_E_RD: begin
        f_q <= fsum[17:2];
        if (!active_q) ge_q <= ssg_pkg::OneQ15;
      end
      ssg_pkg::B_E_WR: ge_q <= rnd[31:16];
      ssg_pkg::B_SC_IM: res_re_q <= sc_res;
      ssg_pkg::B_SC_FIN: res_im_q <= sc_res;
      ssg_pkg::B_PUT: begin
        // queue the frame's last bin once the previous one has gone out
        if (out_load && last_q && !elast_q) begin
          ej_q    <= k_q;
          gp_q    <= ng0_q;
          gc_q    <= g_q;
          gn_q    <= g_q;
          eh_re_q <= held_re_q;
          eh_im_q <= held_im_q;
          elast_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/spectral_subtraction_gain.sv
`timescale 1ns / 1ps

// Spectral subtraction gain stage for a stream of FFT bins.
// Input channel: bin_real_i/bin_imag_i with in_valid_i, in_stall_o; bins of
// one frame come in order, bin 0 to bin FRAME_POINTS/2, and the frame
// boundary is implied by the count.
// Output channel: out_real_o/out_imag_o/frame_last_o with out_valid_o and
// out_stall_i. Each bin leaves scaled by its smoothed gain at the end of the
// next bin's pass through the back engine; the last bin of a frame leaves
// right behind its neighbour, flagged by frame_last_o.
// The bin rate is set by the 67-step bit-serial divider and the shared 24x24
// multiplier in the back engine, which takes a new bin from the queue only
// once it is through with the last; the frame's last bin adds a pass for its
// second result. A stalled receiver holds the output register; the engine then waits.
// A two-entry queue parts the front (bin counting, phase) from the back.
// Reset: after rst_ni rises, the engine sweeps all FRAME_POINTS/2+1 entries
// of the noise and gain stores with in_stall_o high; registers take defaults.
// The user must write them over the APB port only while no bin is in flight;
// the block itself does not enforce it.
module spectral_subtraction_gain #(
  parameter int FRAME_POINTS = ssg_pkg::FramePoints
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [23:0]         bin_real_i,
  input  logic signed [23:0]         bin_imag_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [23:0]         out_real_o,
  output logic signed [23:0]         out_imag_o,
  output logic                       frame_last_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ssg_pkg::AddrW-1:0]  paddr,
  input  logic [ssg_pkg::ApbW-1:0]   pwdata,
  output logic [ssg_pkg::ApbW-1:0]   prdata,
  output logic                       pready
);

  localparam int BinCount = FRAME_POINTS / 2 + 1;
  localparam int KW       = $clog2(BinCount);
  localparam int ItemW    = 2 * ssg_pkg::DataW + KW + 2;

  ssg_pkg::cfg_t     cfg_q;
  ssg_pkg::reg_idx_e reg_idx;

  logic                push, pop, q_full, q_empty, clearing;
  logic [KW-1:0]       front_k;
  logic                front_last, front_active;
  logic [ItemW-1:0]    push_data, head;

  // register file: writes complete on the access phase
  assign pready  = 1'b1;
  assign reg_idx = ssg_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.over_sub     <= 16'd8192;
      cfg_q.min_gain     <= 16'd2621;
      cfg_q.noise_smooth <= 16'd63570;
      cfg_q.gain_smooth  <= 16'd39322;
      cfg_q.update_ratio <= 16'd10240;
      cfg_q.init_frames  <= 4'd12;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        ssg_pkg::REG_OVER_SUB:     cfg_q.over_sub     <= pwdata[15:0];
        ssg_pkg::REG_MIN_GAIN:     cfg_q.min_gain     <= pwdata[15:0];
        ssg_pkg::REG_NOISE_SMOOTH: cfg_q.noise_smooth <= pwdata[15:0];
        ssg_pkg::REG_GAIN_SMOOTH:  cfg_q.gain_smooth  <= pwdata[15:0];
        ssg_pkg::REG_UPDATE_RATIO: cfg_q.update_ratio <= pwdata[15:0];
        ssg_pkg::REG_INIT_FRAMES:  cfg_q.init_frames  <= pwdata[3:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ssg_pkg::REG_OVER_SUB:     prdata = {16'd0, cfg_q.over_sub};
      ssg_pkg::REG_MIN_GAIN:     prdata = {16'd0, cfg_q.min_gain};
      ssg_pkg::REG_NOISE_SMOOTH: prdata = {16'd0, cfg_q.noise_smooth};
      ssg_pkg::REG_GAIN_SMOOTH:  prdata = {16'd0, cfg_q.gain_smooth};
      ssg_pkg::REG_UPDATE_RATIO: prdata = {16'd0, cfg_q.update_ratio};
      ssg_pkg::REG_INIT_FRAMES:  prdata = {28'd0, cfg_q.init_frames};
      default:                   prdata = '0;
    endcase
  end

  // front: count bins and frames, pick the phase of each transaction
  ssg_front #(.FRAME_POINTS(FRAME_POINTS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .queue_full_i (q_full),
    .clearing_i   (clearing),
    .init_frames_i(cfg_q.init_frames),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .k_o          (front_k),
    .last_o       (front_last),
    .active_o     (front_active)
  );

  assign push_data = {bin_real_i, bin_imag_i, front_k, front_last, front_active};

  ssg_queue #(.Width(ItemW)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // back: noise tracking, gain, smoothing and scaling
  ssg_back #(.FRAME_POINTS(FRAME_POINTS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (~q_empty),
    .item_re_i    (head[ItemW-1 -: 24]),
    .item_im_i    (head[ItemW-25 -: 24]),
    .item_k_i     (head[KW+1:2]),
    .item_last_i  (head[1]),
    .item_active_i(head[0]),
    .item_pop_o   (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_real_o   (out_real_o),
    .out_imag_o   (out_imag_o),
    .frame_last_o (frame_last_o)
  );

endmodule

>>> hw/rtl/ssg_checker.sv
`timescale 1ns / 1ps

module ssg_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [23:0]        out_real_o,
  input logic signed [23:0]        out_imag_o,
  input logic                      frame_last_o,
  input logic                      psel,
  input logic                      penable,
  input logic                      pwrite,
  input logic [ssg_pkg::AddrW-1:0] paddr,
  input logic [ssg_pkg::ApbW-1:0]  pwdata,
  input logic [ssg_pkg::ApbW-1:0]  prdata
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_real_o) &&
      $stable(out_imag_o) && $stable(frame_last_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

  // the store sweep must hold off input right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> in_stall_o)
    else $error("input taken during store sweep");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && !pwrite && $past(rst_ni) &&
     $past(psel && penable && pwrite) && paddr == $past(paddr) &&
     paddr[4:2] == ssg_pkg::REG_OVER_SUB)
    |-> prdata[15:0] == $past(pwdata[15:0]))
    else $error("register readback mismatch");

endmodule

bind spectral_subtraction_gain ssg_checker u_ssg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_real_o  (out_real_o),
  .out_imag_o  (out_imag_o),
  .frame_last_o(frame_last_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);
